### design/brw_pkg.sv
// ----------------------------------------------------------------------------
// brw_pkg: shared definitions for the block reorder window
// Field widths, default window size, result limit, slot entry layout and controller states.
// ----------------------------------------------------------------------------
package brw_pkg;

  localparam int WINDOW_SLOTS_DEF = 16;
  localparam int MAX_RESULTS      = 16;

  localparam int SEQ_W  = 16;
  localparam int WORD_W = 64;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 16;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  length;
  } brw_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE,
    ST_CHECK,
    ST_DRAIN
  } brw_state_e;

endpackage

### design/brw_slot_div.sv
// ----------------------------------------------------------------------------
// brw_slot_div: slot index from sequence number
// Sequence modulo window size by reciprocal multiply; the quotient is
// registered, the remainder is formed in the following cycle.
// ----------------------------------------------------------------------------
module brw_slot_div #(
  parameter int WINDOW_SLOTS = brw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic [brw_pkg::SEQ_W-1:0]       seq_i,
  output logic [$clog2(WINDOW_SLOTS)-1:0] slot_o
);

  localparam int SlotW  = $clog2(WINDOW_SLOTS);
  localparam int ShiftW = brw_pkg::SEQ_W + SlotW;
  localparam int ProdW  = ShiftW + brw_pkg::SEQ_W;
  // ceil(2^ShiftW / WINDOW_SLOTS): exact floor division for any 16-bit input
  localparam longint unsigned MultL =
    ((64'd1 << ShiftW) + WINDOW_SLOTS - 1) / WINDOW_SLOTS;
  localparam logic [ProdW-1:0] Mult = ProdW'(MultL);

  logic [ProdW-1:0]              prod;
  logic [brw_pkg::SEQ_W-1:0]     seq_q;
  logic [brw_pkg::SEQ_W-1:0]     quot_q;
  logic [brw_pkg::SEQ_W-1:0]     back;
  logic [brw_pkg::SEQ_W-1:0]     rem;

  assign prod = {{(ProdW-brw_pkg::SEQ_W){1'b0}}, seq_i} * Mult;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seq_q  <= seq_i;
      quot_q <= prod[ShiftW +: brw_pkg::SEQ_W];
    end
  end

  assign back   = quot_q * brw_pkg::SEQ_W'(WINDOW_SLOTS);
  assign rem    = seq_q - back;
  assign slot_o = rem[SlotW-1:0];

endmodule

### design/brw_slot_mem.sv
// ----------------------------------------------------------------------------
// brw_slot_mem: slot payload storage
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module brw_slot_mem #(
  parameter int DEPTH = brw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  brw_pkg::brw_entry_t      wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output brw_pkg::brw_entry_t      rdata_o
);

  brw_pkg::brw_entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/block_reorder_window_top.sv
// ----------------------------------------------------------------------------
// block_reorder_window_top: selective-repeat receive window
// Stores numbered packets by slot and releases a full window in slot order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one packet per beat. The
//   slot is packet_sequence_i modulo WINDOW_SLOTS; a packet hitting an
//   occupied slot is dropped. Output channel (out_valid_o / out_stall_i)
//   carries released packets in slot order, last_of_window_o on the final one.
//   cfg_we_i loads cfg_total_packets_i as the outstanding packet count.
// Packet flow:
//   A packet passes through the modulo quotient, store and window check steps,
//   and no new packet is accepted until the controller is back in idle; a
//   dropped duplicate skips the check and frees the input sooner. On a release
//   the controller walks the slot memory through its single read port, one
//   slot per cycle while the output is not stalled; the first beat passes
//   through the read data, pending and output registers. in_stall_o is high
//   meanwhile.
// Reset:
//   All slots empty, outstanding count and released base zero, no output.
// Stall:
//   A stalled output beat holds; the drain waits until the register is free.
// ----------------------------------------------------------------------------
module block_reorder_window_top #(
  parameter int WINDOW_SLOTS = brw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [brw_pkg::CNT_W-1:0]   cfg_total_packets_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [brw_pkg::SEQ_W-1:0]   packet_sequence_i,
  input  logic [brw_pkg::WORD_W-1:0]  packet_word_i,
  input  logic [brw_pkg::LEN_W-1:0]   packet_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brw_pkg::SEQ_W-1:0]   out_sequence_o,
  output logic [brw_pkg::WORD_W-1:0]  out_word_o,
  output logic [brw_pkg::LEN_W-1:0]   out_length_o,
  output logic                        last_of_window_o
);

  localparam int SlotW = $clog2(WINDOW_SLOTS);
  localparam int NeedW = $clog2(WINDOW_SLOTS + 1);
  localparam int Lim   = (WINDOW_SLOTS < brw_pkg::MAX_RESULTS) ?
                         WINDOW_SLOTS : brw_pkg::MAX_RESULTS;
  localparam int CurW  = SlotW + 1;

  brw_pkg::brw_state_e state_q, state_d;

  logic [WINDOW_SLOTS-1:0]    filled_q;
  logic [brw_pkg::CNT_W-1:0]  outst_q;
  logic [brw_pkg::SEQ_W-1:0]  base_q;
  logic [CurW-1:0]            cur_q;
  logic                       pend_v_q;
  logic                       out_v_q;

  logic [brw_pkg::WORD_W-1:0] word_q;
  logic [brw_pkg::LEN_W-1:0]  len_q;
  brw_pkg::brw_entry_t        pend_q;
  logic [brw_pkg::SEQ_W-1:0]  pend_seq_q;
  brw_pkg::brw_entry_t        out_entry_q;
  logic [brw_pkg::SEQ_W-1:0]  out_seq_q;
  logic                       out_last_q;

  logic [SlotW-1:0]           slot;
  logic                       dup;
  logic [NeedW-1:0]           needed;
  logic [WINDOW_SLOTS:0]      one_sh;
  logic [WINDOW_SLOTS:0]      mask_full;
  logic [WINDOW_SLOTS-1:0]    mask;
  logic                       release_ok;
  logic [SlotW-1:0]           cur_idx;
  logic [CurW-1:0]            cur_nxt;
  logic                       cur_ok;
  logic                       out_free;
  logic                       emit;
  logic                       take;
  logic                       drain_done;
  logic                       in_accept;

  logic                       mem_we;
  logic                       mem_re;
  logic [SlotW-1:0]           mem_raddr;
  brw_pkg::brw_entry_t        mem_wdata;
  brw_pkg::brw_entry_t        mem_rdata;

  brw_slot_div #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_div (
    .clk_i  (clk_i),
    .load_i (in_accept),
    .seq_i  (packet_sequence_i),
    .slot_o (slot)
  );

  brw_slot_mem #(
    .DEPTH(WINDOW_SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_accept = in_valid_i && (state_q == brw_pkg::ST_IDLE);
  assign dup       = filled_q[slot];

  assign needed    = (outst_q < brw_pkg::CNT_W'(WINDOW_SLOTS)) ?
                     outst_q[NeedW-1:0] : NeedW'(WINDOW_SLOTS);
  assign one_sh    = (WINDOW_SLOTS+1)'(1) << needed;
  assign mask_full = one_sh - (WINDOW_SLOTS+1)'(1);
  assign mask      = mask_full[WINDOW_SLOTS-1:0];
  assign release_ok = (outst_q != '0) && ((filled_q & mask) == mask);

  // Read data belongs to slot cur_q; the walk stops at the result limit,
  // an empty slot or a zero length.
  assign cur_idx  = cur_q[SlotW-1:0];
  assign cur_nxt  = cur_q + CurW'(1);
  assign cur_ok   = (cur_q != CurW'(Lim)) && filled_q[cur_idx] &&
                    (mem_rdata.length != '0);
  assign out_free = !out_v_q || !out_stall_i;

  assign emit       = (state_q == brw_pkg::ST_DRAIN) && pend_v_q && out_free;
  assign take       = (state_q == brw_pkg::ST_DRAIN) && cur_ok &&
                      (!pend_v_q || out_free);
  assign drain_done = (state_q == brw_pkg::ST_DRAIN) && !cur_ok &&
                      (!pend_v_q || out_free);

  assign mem_wdata.word   = word_q;
  assign mem_wdata.length = len_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brw_pkg::ST_IDLE: begin
        if (in_accept) state_d = brw_pkg::ST_STORE;
      end
      brw_pkg::ST_STORE: begin
        state_d = dup ? brw_pkg::ST_IDLE : brw_pkg::ST_CHECK;
      end
      brw_pkg::ST_CHECK: begin
        state_d = release_ok ? brw_pkg::ST_DRAIN : brw_pkg::ST_IDLE;
      end
      brw_pkg::ST_DRAIN: begin
        if (drain_done) state_d = brw_pkg::ST_IDLE;
      end
      default: state_d = brw_pkg::ST_IDLE;
    endcase
  end

  // Controls
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = cur_nxt[SlotW-1:0];
    case (state_q)
      brw_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      brw_pkg::ST_STORE: begin
        mem_we = !dup;
      end
      brw_pkg::ST_CHECK: begin
        mem_re    = release_ok;
        mem_raddr = '0;
      end
      brw_pkg::ST_DRAIN: begin
        mem_re = take;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= brw_pkg::ST_IDLE;
      filled_q <= '0;
      outst_q  <= '0;
      base_q   <= '0;
      cur_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == brw_pkg::ST_STORE && !dup) begin
        filled_q[slot] <= 1'b1;
      end else if (drain_done) begin
        filled_q <= '0;
      end

      if (cfg_we_i) begin
        outst_q <= cfg_total_packets_i;
      end else if (drain_done) begin
        outst_q <= outst_q - brw_pkg::CNT_W'(needed);
      end

      if (drain_done) begin
        base_q <= base_q + brw_pkg::SEQ_W'(needed);
      end

      if (state_q == brw_pkg::ST_CHECK) begin
        cur_q    <= '0;
        pend_v_q <= 1'b0;
      end else begin
        if (take) cur_q <= cur_nxt;
        if (take) begin
          pend_v_q <= 1'b1;
        end else if (emit) begin
          pend_v_q <= 1'b0;
        end
      end

      if (emit) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q <= packet_word_i;
      len_q  <= packet_length_i;
    end
    if (take) begin
      pend_q     <= mem_rdata;
      pend_seq_q <= base_q + brw_pkg::SEQ_W'(cur_q);
    end
    // Last beat when the next slot ends the walk
    if (emit) begin
      out_entry_q <= pend_q;
      out_seq_q   <= pend_seq_q;
      out_last_q  <= !cur_ok;
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_sequence_o   = out_seq_q;
  assign out_word_o       = out_entry_q.word;
  assign out_length_o     = out_entry_q.length;
  assign last_of_window_o = out_last_q;

endmodule

### design/brw_checker.sv
// ----------------------------------------------------------------------------
// brw_port_checks: port-level checks for the block reorder window
// Watches the top-level ports only; bound to block_reorder_window_top.
// ----------------------------------------------------------------------------
module brw_port_checks (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [brw_pkg::SEQ_W-1:0]   out_sequence_o,
  input logic [brw_pkg::WORD_W-1:0]  out_word_o,
  input logic [brw_pkg::LEN_W-1:0]   out_length_o,
  input logic                        last_of_window_o
);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_sequence_o) && $stable(out_word_o) &&
       $stable(out_length_o) && $stable(last_of_window_o)))
    else $error("output beat changed while stalled");

  // An accepted packet occupies at least the store cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted during packet processing");

  // Zero-length slots never leave the window
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_length_o != '0))
    else $error("released packet with zero length");

  // Reset leaves the block idle with no output
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (!out_valid_o && !in_stall_o))
    else $error("block not idle during reset");

endmodule

bind block_reorder_window_top brw_port_checks u_brw_port_checks (.*);
